// ===== design/mmsef_pkg.sv =====
// ----------------------------------------------------------------------------
// mmsef_pkg
// Shared constants and types of the mask majority smoother with edge fill.
// ----------------------------------------------------------------------------
package mmsef_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned NUM_PANES_DEF = 3;

  localparam int unsigned PANE_W = 16;   // one colour value
  localparam int unsigned MASK_W = 8;    // mask byte
  localparam int unsigned CFG_W  = 11;   // configuration register width
  localparam int unsigned ROW_W  = 11;   // row counter width
  localparam int unsigned DATA_W = 56;   // mask byte plus three panes
  localparam int unsigned SUM_W  = 19;   // sum of up to eight colours
  localparam int unsigned CNT_W  = 4;    // count of up to eight neighbors

  localparam logic [MASK_W-1:0] SET_LEVEL  = 8'd128;
  localparam logic [MASK_W-1:0] FULL_MASK  = 8'hFF;
  localparam logic [CNT_W-1:0]  MAJORITY   = 4'd5;
  localparam logic [ROW_W-1:0]  MAX_HEIGHT = 11'd1024;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // Vote result of the current 3x3 window.
  typedef struct packed {
    logic             set;
    logic             fill;
    logic [CNT_W-1:0] cnt;
  } fill_t;

endpackage

// ===== design/mmsef_line_mem.sv =====
// ----------------------------------------------------------------------------
// mmsef_line_mem
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmsef_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mmsef_fill.sv =====
// ----------------------------------------------------------------------------
// mmsef_fill
// Majority vote over the 3x3 window and border-neighbor sums for edge fill.
// ----------------------------------------------------------------------------
module mmsef_fill #(
  parameter int unsigned PANES = 3
) (
  input  logic [2:0][2:0]                                mwin_i,
  input  logic [2:0][2:0][PANES*mmsef_pkg::PANE_W-1:0]   cwin_i,
  output mmsef_pkg::fill_t                               fill_o,
  output logic [PANES-1:0][mmsef_pkg::SUM_W-1:0]         sum_o
);

  localparam int unsigned PW = PANES * mmsef_pkg::PANE_W;

  logic [mmsef_pkg::CNT_W-1:0] ones;
  logic [mmsef_pkg::CNT_W-1:0] cnt;
  logic [7:0]                  en;
  logic [7:0][PW-1:0]          nb;

  always_comb begin
    ones = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        ones = ones + mmsef_pkg::CNT_W'(mwin_i[r][k]);
      end
    end
  end

  // Border tests; bottom-center reuses the top-center test.
  always_comb begin
    en[0] = mwin_i[0][0] && (!mwin_i[1][0] || !mwin_i[0][1]);
    en[1] = mwin_i[0][1] && (!mwin_i[0][0] || !mwin_i[0][2]);
    en[2] = mwin_i[0][2] && (!mwin_i[1][2] || !mwin_i[0][1]);
    en[3] = mwin_i[1][0] && (!mwin_i[0][0] || !mwin_i[2][0]);
    en[4] = mwin_i[1][2] && (!mwin_i[0][2] || !mwin_i[2][2]);
    en[5] = mwin_i[2][0] && (!mwin_i[1][0] || !mwin_i[2][1]);
    en[6] = mwin_i[2][1] && (!mwin_i[0][0] || !mwin_i[0][2]);
    en[7] = mwin_i[2][2] && (!mwin_i[1][2] || !mwin_i[2][1]);
    nb[0] = cwin_i[0][0];
    nb[1] = cwin_i[0][1];
    nb[2] = cwin_i[0][2];
    nb[3] = cwin_i[1][0];
    nb[4] = cwin_i[1][2];
    nb[5] = cwin_i[2][0];
    nb[6] = cwin_i[2][1];
    nb[7] = cwin_i[2][2];
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + mmsef_pkg::CNT_W'(en[i]);
    end
  end

  always_comb begin
    for (int p = 0; p < PANES; p++) begin
      sum_o[p] = '0;
      for (int i = 0; i < 8; i++) begin
        if (en[i]) begin
          sum_o[p] = sum_o[p] +
                     mmsef_pkg::SUM_W'(nb[i][p*mmsef_pkg::PANE_W +: mmsef_pkg::PANE_W]);
        end
      end
    end
  end

  assign fill_o.set  = (ones >= mmsef_pkg::MAJORITY);
  assign fill_o.fill = (ones >= mmsef_pkg::MAJORITY) && !mwin_i[1][1];
  assign fill_o.cnt  = cnt;

endmodule

// ===== design/mmsef_div.sv =====
// ----------------------------------------------------------------------------
// mmsef_div
// Restoring divider, one quotient bit per cycle, one lane per pane.
// ----------------------------------------------------------------------------
module mmsef_div #(
  parameter int unsigned LANES = 3
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [LANES-1:0][mmsef_pkg::SUM_W-1:0]  num_i,
  input  logic [mmsef_pkg::CNT_W-1:0]             den_i,
  output logic                                    busy_o,
  output logic [LANES-1:0][mmsef_pkg::PANE_W-1:0] quo_o
);

  localparam int unsigned SW    = mmsef_pkg::SUM_W;
  localparam int unsigned DW    = mmsef_pkg::CNT_W;
  localparam int unsigned STEPW = $clog2(SW + 1);

  logic                            busy_q;
  logic [STEPW-1:0]                step_q;
  logic [DW-1:0]                   den_q;
  logic [LANES-1:0][SW-1:0]        quo_q;
  logic [LANES-1:0][DW-1:0]        rem_q;
  logic [LANES-1:0][SW-1:0]        quo_d;
  logic [LANES-1:0][DW-1:0]        rem_d;
  logic [DW:0]                     sh;

  always_comb begin
    sh = '0;
    for (int l = 0; l < LANES; l++) begin
      sh = {rem_q[l], quo_q[l][SW-1]};
      if (sh >= {1'b0, den_q}) begin
        rem_d[l] = DW'(sh - {1'b0, den_q});
        quo_d[l] = {quo_q[l][SW-2:0], 1'b1};
      end else begin
        rem_d[l] = DW'(sh);
        quo_d[l] = {quo_q[l][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEPW'(SW);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEPW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = quo_q[l][mmsef_pkg::PANE_W-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== design/mask_majority_smooth_edge_fill_core.sv =====
// ----------------------------------------------------------------------------
// mask_majority_smooth_edge_fill_core
// 3x3 majority smoothing of a raster mask with edge colour fill.
// ----------------------------------------------------------------------------
// Each item passes through accept, line-store read, window vote and result; a
// pixel that is newly set and edge-filled also passes through the 19-step
// divider that forms the neighbor mean. Two line stores of MAX_WIDTH entries
// hold the mask bits of the two previous rows with the input colours of the
// previous row, and the filled colours of the row before; they start undefined
// and need no clearing pass. Results run one row and one column behind the
// input, so after each image send one padding row and one more item.
// ----------------------------------------------------------------------------
module mask_majority_smooth_edge_fill_core #(
  parameter int unsigned MAX_WIDTH = mmsef_pkg::MAX_WIDTH_DEF,
  parameter int unsigned NUM_PANES = mmsef_pkg::NUM_PANES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // mask_in[7:0], pane0_in[23:8], pane1_in[39:24], pane2_in[55:40]
  input  logic [mmsef_pkg::DATA_W-1:0]  s_axis_tdata,
  // pad_row[0]
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mask_out[7:0], pane0_out[23:8], pane1_out[39:24], pane2_out[55:40]
  output logic [mmsef_pkg::DATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [mmsef_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned PANES = (NUM_PANES < 3) ? NUM_PANES : 3;
  localparam int unsigned PANEW = mmsef_pkg::PANE_W;
  localparam int unsigned PW    = PANES * PANEW;
  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WC    = (CW > mmsef_pkg::CFG_W) ? CW : mmsef_pkg::CFG_W;
  localparam int unsigned RW    = mmsef_pkg::ROW_W;

  mmsef_pkg::state_e state_q, state_d;

  logic [mmsef_pkg::CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]               w_eff;
  logic [RW-1:0]               h_eff;

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // counter resolution at accept
  logic          wrap, restart, c0, top_ok, mid_ok, bot_ok, emit, last;
  logic [RW-1:0] r_a, r_cur, y;
  logic [AW-1:0] c_a, c_cur, x;
  logic [CW-1:0] cn;
  logic [RW:0]   r_ext, h_ext;
  logic [PW-1:0] bcol;
  logic          accept;

  // per-item registers
  logic          rpar_q, c0_q, emit_q, last_q, top_ok_q, mid_ok_q, bset_q, set_q;
  logic [AW-1:0] c_q, x_q;
  logic [PW-1:0] bcol_q, v_q;

  // window
  logic [2:0][2:0]         mwin_q;
  logic [2:0][2:0][PW-1:0] cwin_q;
  logic [2:0]              ncm_q, colm;
  logic [2:0][PW-1:0]      ncc_q, colc;

  // line stores
  logic [PW+1:0] rda, wda;
  logic [PW-1:0] rdb;
  logic [1:0]    mbits, mbits_new;
  logic          wea, web;

  mmsef_pkg::fill_t               fill;
  logic [PANES-1:0][mmsef_pkg::SUM_W-1:0] sums;
  logic [PANES-1:0][PANEW-1:0]    quo;
  logic                           div_start, div_busy;
  logic [mmsef_pkg::CNT_W-1:0]    den;

  logic                           out_valid_q, out_last_q, out_free;
  logic [mmsef_pkg::DATA_W-1:0]   out_data_q, out_data_d;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mmsef_pkg::CFG_W'(1024);
      height_q <= mmsef_pkg::CFG_W'(1024);
    end else if (cfg_we_i) begin
      case (mmsef_pkg::cfg_reg_e'(cfg_idx_i))
        mmsef_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        mmsef_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (WC'(width_q) > WC'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (height_q > mmsef_pkg::MAX_HEIGHT) begin
      h_eff = mmsef_pkg::MAX_HEIGHT;
    end else begin
      h_eff = height_q;
    end
  end

  // ---------------- position of the incoming item ----------------
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wrap    = (CW'(col_q) >= w_eff);
    r_a     = wrap ? row_q + 1'b1 : row_q;
    c_a     = wrap ? '0 : col_q;
    restart = ({1'b0, r_a} > ({1'b0, h_eff} + 1'b1));
    r_cur   = restart ? '0 : r_a;
    c_cur   = restart ? '0 : c_a;
    c0      = (c_cur == '0);
    r_ext   = {1'b0, r_cur};
    h_ext   = {1'b0, h_eff};
    top_ok  = (r_cur >= RW'(2)) && (r_ext < h_ext + 2'd2);
    mid_ok  = (r_cur >= RW'(1)) && (r_ext < h_ext + 1'b1);
    bot_ok  = (r_cur < h_eff) && !s_axis_tuser[0];
    emit    = c0 ? top_ok : mid_ok;
    x       = c0 ? AW'(w_eff - 1'b1) : c_cur - 1'b1;
    y       = c0 ? r_cur - RW'(2) : r_cur - RW'(1);
    last    = (y == h_eff - 1'b1) && (CW'(x) == w_eff - 1'b1);
    cn      = CW'(c_cur) + 1'b1;
    if (c0 && (r_ext >= h_ext + 1'b1)) begin
      row_d = '0;
      col_d = '0;
    end else if (cn >= w_eff) begin
      row_d = r_cur + 1'b1;
      col_d = '0;
    end else begin
      row_d = r_cur;
      col_d = AW'(cn);
    end
    for (int p = 0; p < PANES; p++) begin
      bcol[p*PANEW +: PANEW] = bot_ok ? s_axis_tdata[mmsef_pkg::MASK_W + p*PANEW +: PANEW]
                                      : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rpar_q   <= r_cur[0];
      c_q      <= c_cur;
      x_q      <= x;
      c0_q     <= c0;
      emit_q   <= emit;
      last_q   <= last;
      top_ok_q <= top_ok;
      mid_ok_q <= mid_ok;
      bset_q   <= bot_ok && (s_axis_tdata[mmsef_pkg::MASK_W-1:0] >= mmsef_pkg::SET_LEVEL);
      bcol_q   <= bcol;
    end
  end

  // ---------------- line stores ----------------
  // store A: {mask bit of odd rows, mask bit of even rows, input colours}
  mmsef_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(PW + 2)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wea),
    .waddr_i (c_q),
    .wdata_i (wda),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (rda)
  );

  // store B: filled colours of the row two above the input
  mmsef_line_mem #(.DEPTH(MAX_WIDTH), .WIDTH(PW)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (web),
    .waddr_i (x_q),
    .wdata_i (v_q),
    .re_i    (accept),
    .raddr_i (c_cur),
    .rdata_o (rdb)
  );

  always_comb begin
    mbits            = rda[PW+1:PW];
    mbits_new        = mbits;
    mbits_new[rpar_q] = bset_q;
    wda              = {mbits_new, bcol_q};
    colm[0]          = top_ok_q && mbits[rpar_q];
    colm[1]          = mid_ok_q && mbits[!rpar_q];
    colm[2]          = bset_q;
    colc[0]          = top_ok_q ? rdb : '0;
    colc[1]          = mid_ok_q ? rda[PW-1:0] : '0;
    colc[2]          = bcol_q;
  end

  assign wea = (state_q == mmsef_pkg::ST_LOAD);
  assign web = (state_q == mmsef_pkg::ST_OUT) && emit_q && out_free;

  // ---------------- vote and fill ----------------
  mmsef_fill #(.PANES(PANES)) u_fill (
    .mwin_i (mwin_q),
    .cwin_i (cwin_q),
    .fill_o (fill),
    .sum_o  (sums)
  );

  assign den       = (fill.cnt == '0) ? mmsef_pkg::CNT_W'(1) : fill.cnt;
  assign div_start = (state_q == mmsef_pkg::ST_SUM) && emit_q && fill.fill;

  mmsef_div #(.LANES(PANES)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sums),
    .den_i   (den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // ---------------- sequencer ----------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == mmsef_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mmsef_pkg::ST_IDLE: if (accept) state_d = mmsef_pkg::ST_LOAD;
      mmsef_pkg::ST_LOAD: state_d = mmsef_pkg::ST_SUM;
      mmsef_pkg::ST_SUM:  state_d = div_start ? mmsef_pkg::ST_DIV : mmsef_pkg::ST_OUT;
      mmsef_pkg::ST_DIV:  if (!div_busy) state_d = mmsef_pkg::ST_OUT;
      mmsef_pkg::ST_OUT:  if (!emit_q || out_free) state_d = mmsef_pkg::ST_IDLE;
      default:            state_d = mmsef_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmsef_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window shift, center update and row-start clear
  // on a one-pixel-wide image the top neighbor is the pixel just filled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mwin_q <= '0;
      cwin_q <= '0;
    end else begin
      case (state_q)
        mmsef_pkg::ST_LOAD: begin
          for (int r = 0; r < 3; r++) begin
            mwin_q[r][0] <= mwin_q[r][1];
            mwin_q[r][1] <= mwin_q[r][2];
            mwin_q[r][2] <= c0_q ? 1'b0 : colm[r];
            cwin_q[r][0] <= cwin_q[r][1];
            cwin_q[r][1] <= cwin_q[r][2];
            cwin_q[r][2] <= c0_q ? '0 : colc[r];
          end
        end
        mmsef_pkg::ST_OUT: begin
          if (!emit_q || out_free) begin
            if (c0_q) begin
              for (int r = 0; r < 3; r++) begin
                mwin_q[r] <= {ncm_q[r], 2'b00};
                cwin_q[r] <= {((r == 0) && emit_q && (x_q == c_q)) ? v_q : ncc_q[r],
                              {(2*PW){1'b0}}};
              end
            end else if (emit_q) begin
              cwin_q[1][1] <= v_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mmsef_pkg::ST_LOAD) begin
      ncm_q <= colm;
      ncc_q <= colc;
    end
    if (state_q == mmsef_pkg::ST_SUM) begin
      set_q <= fill.set;
      v_q   <= cwin_q[1][1];
    end
    if ((state_q == mmsef_pkg::ST_DIV) && !div_busy) begin
      v_q <= quo;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_data_d = '0;
    out_data_d[mmsef_pkg::MASK_W-1:0] = set_q ? mmsef_pkg::FULL_MASK : '0;
    for (int p = 0; p < PANES; p++) begin
      out_data_d[mmsef_pkg::MASK_W + p*PANEW +: PANEW] = v_q[p*PANEW +: PANEW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (web) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (web) begin
      out_data_q <= out_data_d;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== design/mmsef_chk.sv =====
// ----------------------------------------------------------------------------
// mmsef_chk
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
module mmsef_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [mmsef_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);

  // one item in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // smoothed mask is binary
  a_mask_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'h00 || m_axis_tdata[7:0] == 8'hFF))
    else $error("mask out neither 0 nor 255");

  // a result is raised only from an item in work
  a_result_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while block idle");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("output item dropped under stall");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output item changed under stall");

endmodule

bind mask_majority_smooth_edge_fill_core mmsef_chk u_mmsef_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
